@@ rtl/archive_word_stream_decrypt_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the archive word stream decrypt block
// Wraps concurrent assertions on i_clk with a reset disable.
// ---------------------------------------------------------------------------
`ifndef ARCHIVE_WORD_STREAM_DECRYPT_TOP_ASSERT_SVH
`define ARCHIVE_WORD_STREAM_DECRYPT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AWSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// next-cycle implication
`define AWSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define AWSD_ASSERT_NOW(label, ante, cons)
`define AWSD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/awsd_pkg.sv @@
// ---------------------------------------------------------------------------
// awsd_pkg
// Types, key constants and the mix table ROM for the word stream decryptor.
// ---------------------------------------------------------------------------
package awsd_pkg;

    typedef logic [31:0] t_word;
    typedef t_word t_mix_table [0:255];

    localparam t_word FEEDBACK_INIT = 32'hEEEE_EEEE;
    localparam t_word ROLL_MIX      = 32'h1111_1111;
    localparam t_word LCG_SEED      = 32'h0010_0001;
    localparam t_word LCG_MOD       = 32'h002A_AAAB;
    localparam t_word LCG_MUL       = 32'd125;
    localparam int    ROLL_SHL      = 21;
    localparam int    ROLL_SHR      = 11;
    localparam int    FB_SHL        = 5;
    localparam t_word FB_ADD        = 32'd3;

    // Generate the fifth slice of the interleaved LCG table at elaboration.
    function automatic t_mix_table build_mix_table();
        t_mix_table tab;
        t_word      s;
        t_word      hi;
        s = LCG_SEED;
        for (int k = 0; k < 256; k++) begin
            for (int sl = 0; sl < 5; sl++) begin
                s  = (s * LCG_MUL + 32'd3) % LCG_MOD;
                hi = {s[15:0], 16'h0000};
                s  = (s * LCG_MUL + 32'd3) % LCG_MOD;
                if (sl == 4) begin
                    tab[k] = hi | {16'h0000, s[15:0]};
                end
            end
        end
        return tab;
    endfunction

    localparam t_mix_table MIX_TABLE = build_mix_table();

endpackage

@@ rtl/archive_word_stream_decrypt_top.sv @@
// ---------------------------------------------------------------------------
// archive_word_stream_decrypt_top
// Path: input beat to result beat through the input reg, then the result reg.
// Throughput: one word per cycle unless stalled; the key chain closes through one table
// read and a few 32-bit adds between the input register and the key registers.
// Reset: synchronous active low; clears valids, rolling key to 0, feedback
// key to 0xEEEEEEEE. The mix table is a constant ROM.
// ---------------------------------------------------------------------------
`include "archive_word_stream_decrypt_top_assert.svh"

module archive_word_stream_decrypt_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  awsd_pkg::t_word      i_cipher_word,
    input  logic                 i_block_start,
    input  awsd_pkg::t_word      i_block_key,
    output logic                 o_valid,
    input  logic                 i_stall,
    output awsd_pkg::t_word      o_plain_word
);
    import awsd_pkg::*;

    logic  r_in_valid;
    t_word r_in_cipher;
    logic  r_in_start;
    t_word r_in_key;

    logic  r_out_valid;
    t_word r_out_plain;

    t_word r_rolling;
    t_word r_feedback;

    logic  out_free;
    logic  advance;
    logic  in_accept;

    t_word roll_cur;
    t_word fb_cur;
    t_word fb_mixed;
    t_word n_plain;
    t_word n_rolling;
    t_word n_feedback;

    // Handshake: output slot frees on take, input slot frees on advance
    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    assign o_valid      = r_out_valid;
    assign o_plain_word = r_out_plain;

    // Decrypt the held word and roll both keys
    always_comb begin
        roll_cur   = r_in_start ? r_in_key : r_rolling;
        fb_cur     = r_in_start ? FEEDBACK_INIT : r_feedback;
        fb_mixed   = fb_cur + MIX_TABLE[roll_cur[7:0]];
        n_plain    = r_in_cipher ^ (roll_cur + fb_mixed);
        n_rolling  = (((~roll_cur) << ROLL_SHL) + ROLL_MIX) | (roll_cur >> ROLL_SHR);
        n_feedback = n_plain + fb_mixed + (fb_mixed << FB_SHL) + FB_ADD;
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_accept) begin
            r_in_cipher <= i_cipher_word;
            r_in_start  <= i_block_start;
            r_in_key    <= i_block_key;
        end
    end

    // Advance into the result register and update the key chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rolling   <= '0;
            r_feedback  <= FEEDBACK_INIT;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_rolling   <= n_rolling;
                r_feedback  <= n_feedback;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_plain <= n_plain;
        end
    end

    // Checks on the pipeline and key chain
    `AWSD_ASSERT_NEXT(a_advance_fills_out, advance, r_out_valid)
    `AWSD_ASSERT_NEXT(a_blocked_input_holds, o_stall, r_in_valid && $stable(r_in_cipher))
    `AWSD_ASSERT_NEXT(a_keys_move_on_advance, !advance, $stable(r_rolling) && $stable(r_feedback))
    `AWSD_ASSERT_NOW(a_stall_needs_full_pipe, o_stall, r_in_valid && r_out_valid && i_stall)

endmodule
